>>> design/ftrs_pkg.sv
`default_nettype none

package ftrs_pkg;

    localparam int IDX_W   = 12;
    localparam int SIZE_W  = 11;
    localparam int LO_W    = 10;
    localparam int HI_W    = 11;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 64;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_SIZE_IN_USE = 1'b0;

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_RANGE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ALU_ACC_ADD = 2'd0,
        ALU_ACC_SUB = 2'd1,
        ALU_RMW     = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_cmd_t;

endpackage

`default_nettype wire

>>> design/ftrs_cell_ram.sv
`default_nettype none

module ftrs_cell_ram #(
    parameter int DEPTH = 1024
) (
    input  wire logic                         aclk,
    input  wire ftrs_pkg::ram_cmd_t           cmd,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [ftrs_pkg::SUM_W-1:0]   wr_data,
    output logic      [ftrs_pkg::SUM_W-1:0]   rd_data
);
    import ftrs_pkg::*;

    logic [SUM_W-1:0] cell_mem_reg [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            cell_mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= cell_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/ftrs_alu.sv
`default_nettype none

module ftrs_alu (
    input  wire ftrs_pkg::alu_op_t              op,
    input  wire logic [ftrs_pkg::SUM_W-1:0]     acc,
    input  wire logic [ftrs_pkg::SUM_W-1:0]     rd_data,
    input  wire logic [ftrs_pkg::DELTA_W-1:0]   delta,
    output logic      [ftrs_pkg::SUM_W-1:0]     result
);
    import ftrs_pkg::*;

    logic [SUM_W-1:0] opa;
    logic [SUM_W-1:0] opb;
    logic             cin;

    always_comb begin
        case (op)
            ALU_ACC_ADD: begin
                opa = acc;
                opb = rd_data;
                cin = 1'b0;
            end
            ALU_ACC_SUB: begin
                opa = acc;
                opb = ~rd_data;
                cin = 1'b1;
            end
            ALU_RMW: begin
                opa = rd_data;
                opb = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
                cin = 1'b0;
            end
            default: begin
                opa = acc;
                opb = '0;
                cin = 1'b0;
            end
        endcase
        result = opa + opb + SUM_W'(cin);
    end

endmodule

`default_nettype wire

>>> design/ftrs_ctrl.sv
`default_nettype none

module ftrs_ctrl #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [ftrs_pkg::SIZE_W-1:0]        size_in_use,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic [ftrs_pkg::LO_W-1:0]          s_index_lo,
    input  wire logic [ftrs_pkg::HI_W-1:0]          s_index_hi,
    input  wire logic [ftrs_pkg::DELTA_W-1:0]       s_delta,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ftrs_pkg::SUM_W-1:0]              m_range_sum,
    output logic                                    m_index_error,
    output ftrs_pkg::ram_cmd_t                      cmd,
    output logic [$clog2(MAX_ENTRIES)-1:0]          rd_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]          wr_addr,
    output logic [ftrs_pkg::SUM_W-1:0]              wr_data,
    input  wire logic [ftrs_pkg::SUM_W-1:0]         rd_data
);
    import ftrs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_PRE_HI,
        ST_PRE_LO,
        ST_PUT
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [DELTA_W-1:0] delta_reg, delta_next;
    logic [LO_W-1:0]    lo_reg, lo_next;
    logic               err_reg, err_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]   m_sum_reg, m_sum_next;
    logic               m_err_reg, m_err_next;

    logic [SIZE_W-1:0]  eff_size;
    logic               idx_in_store;
    logic               add_live;
    logic               pre_live;
    logic [IDX_W-1:0]   idx_up;
    logic [IDX_W-1:0]   idx_down;
    logic [IDX_W-1:0]   hi_ext;
    logic [IDX_W-1:0]   lo_m1;
    logic               hi_over;
    alu_op_t            alu_op;
    logic [SUM_W-1:0]   alu_result;

    ftrs_alu u_alu (
        .op      (alu_op),
        .acc     (acc_reg),
        .rd_data (rd_data),
        .delta   (delta_reg),
        .result  (alu_result)
    );

    always_comb begin
        eff_size = (32'(size_in_use) > MAX_ENTRIES) ? SIZE_W'(MAX_ENTRIES) : size_in_use;
        idx_in_store = !idx_reg[IDX_W-1] && (32'(idx_reg[SIZE_W-1:0]) < MAX_ENTRIES);
        add_live = !idx_reg[IDX_W-1] && (idx_reg[SIZE_W-1:0] < eff_size);
        pre_live = !idx_reg[IDX_W-1];
        idx_up   = idx_reg | (idx_reg + IDX_W'(1));
        idx_down = (idx_reg & (idx_reg + IDX_W'(1))) - IDX_W'(1);
        hi_ext   = {{(IDX_W-HI_W){s_index_hi[HI_W-1]}}, s_index_hi};
        lo_m1    = {{(IDX_W-LO_W){1'b0}}, lo_reg} - IDX_W'(1);
        hi_over  = !s_index_hi[HI_W-1] && ({1'b0, s_index_hi[HI_W-2:0]} >= eff_size);
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        delta_next     = delta_reg;
        lo_next        = lo_reg;
        err_next       = err_reg;
        clr_cnt_next   = clr_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_sum_next     = m_sum_reg;
        m_err_next     = m_err_reg;
        cmd            = '0;
        rd_addr        = AW'(idx_reg);
        wr_addr        = pend_addr_reg;
        wr_data        = alu_result;
        alu_op         = ALU_ACC_ADD;

        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en    = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    lo_next    = s_index_lo;
                    delta_next = s_delta;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    err_next   = 1'b0;
                    if (s_req_type == REQ_ADD) begin
                        idx_next   = {{(IDX_W-LO_W){1'b0}}, s_index_lo};
                        state_next = ST_ADD;
                    end else if (hi_over) begin
                        err_next   = 1'b1;
                        state_next = ST_PUT;
                    end else begin
                        idx_next   = hi_ext;
                        state_next = ST_PRE_HI;
                    end
                end
            end
            ST_ADD: begin
                // read next cell while writing back the previous one
                alu_op    = ALU_RMW;
                cmd.wr_en = pend_reg;
                if (add_live) begin
                    cmd.rd_en      = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(idx_reg);
                    idx_next       = idx_up;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_PRE_HI, ST_PRE_LO: begin
                alu_op = (state_reg == ST_PRE_HI) ? ALU_ACC_ADD : ALU_ACC_SUB;
                if (pend_reg) begin
                    acc_next = alu_result;
                end
                if (pre_live) begin
                    cmd.rd_en = idx_in_store;
                    pend_next = idx_in_store;
                    idx_next  = idx_down;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (state_reg == ST_PRE_HI) begin
                            idx_next   = lo_m1;
                            state_next = ST_PRE_LO;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end
                end
            end
            ST_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
        delta_reg     <= delta_next;
        lo_reg        <= lo_next;
        err_reg       <= err_next;
        m_sum_reg     <= m_sum_next;
        m_err_reg     <= m_err_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_range_sum   = m_sum_reg;
    assign m_index_error = m_err_reg;

    a_err_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_range_sum == '0)
        else $error("flagged word carries a nonzero sum");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after accept");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (state_reg == ST_ADD || state_reg == ST_CLEAR))
        else $error("cell write outside update or clear");

    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en && cmd.rd_en |-> wr_addr != rd_addr)
        else $error("read and write hit the same cell");

endmodule

`default_nettype wire

>>> design/fenwick_tree_range_sum_unit.sv
// fenwick tree range-sum unit, zero-indexed, 64-bit cells
// input channel s_*: one word per request. s_req_type add puts s_delta
// (sign-extended) into every cell on the chain i, i|(i+1), ... below the
// effective size min(size_in_use, MAX_ENTRIES); range returns
// prefix(s_index_hi) - prefix(s_index_lo - 1), wrapping at 64 bits.
// result channel m_*: exactly one word per request, m_index_error set and
// m_range_sum zero when a query's upper bound is not below the size.
// size_in_use sits at apb byte address 0, write only while idle.
// one request at a time: a single 64-bit adder and one read / one write
// port of the cell memory walk the tree, one cell per cycle, reads
// overlapped with the accumulate or write-back of the previous cell.
// an add walks its index chain and a query walks the two prefix chains,
// hi first and then lo - 1, before the word is put out; a flagged query
// skips the walks. s_ready comes back as the word is registered, so a new
// request is taken only once the previous word is in the output register.
// after reset the memory is swept to zero, every cell in turn, with
// s_ready low; apb writes are taken during the sweep.
// a finished word waits in an output register while m_ready is low; the
// next request is accepted meanwhile and its result waits for the slot.
`default_nettype none

module fenwick_tree_range_sum_unit #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ftrs_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [ftrs_pkg::DATA_W-1:0]        pwdata,
    output logic      [ftrs_pkg::DATA_W-1:0]        prdata,
    output logic                                    pready,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic [ftrs_pkg::LO_W-1:0]          s_index_lo,
    input  wire logic [ftrs_pkg::HI_W-1:0]          s_index_hi,
    input  wire logic [ftrs_pkg::DELTA_W-1:0]       s_delta,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [ftrs_pkg::SUM_W-1:0]         m_range_sum,
    output logic                                    m_index_error
);
    import ftrs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [SIZE_W-1:0] size_reg;
    logic              cfg_wr;
    ram_cmd_t          cmd;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [SUM_W-1:0]  wr_data;
    logic [SUM_W-1:0]  rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
    assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {{(DATA_W-SIZE_W){1'b0}}, size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    ftrs_cell_ram #(
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    ftrs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .size_in_use   (size_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_index_lo    (s_index_lo),
        .s_index_hi    (s_index_hi),
        .s_delta       (s_delta),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_sum   (m_range_sum),
        .m_index_error (m_index_error),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_data       (rd_data)
    );

endmodule

`default_nettype wire
